@@ rtl/core/sfcs_pkg.sv @@
// Package with shared types and constants of the SPI flash command sequencer.
package sfcs_pkg;
  localparam logic [1:0] MODE_CMD  = 2'd0;
  localparam logic [1:0] MODE_RX   = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERROR   = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  localparam logic [7:0] OPC_READ    = 8'h03;
  localparam logic [7:0] OPC_PROGRAM = 8'h02;
  localparam logic [7:0] OPC_ERASE   = 8'h20;
  localparam logic [7:0] OPC_WREN    = 8'h06;
  localparam logic [7:0] OPC_WRDI    = 8'h04;
  localparam logic [7:0] OPC_RDSR    = 8'h05;

  localparam logic [0:0] REG_WORD_TIMEOUT = 1'd0;
  localparam logic [0:0] REG_POLL_TIMEOUT = 1'd1;

  // Classified request passed from the front part to the back part.
  typedef struct packed {
    logic [1:0]  mode;
    logic        cmd_bad;
    logic [7:0]  opcode;
    logic [23:0] address;
    logic [12:0] length;
    logic        cmd_ok_bus;
    logic [7:0]  rx_byte;
    logic        rx_error;
    logic [7:0]  write_byte;
  } req_t;

  // One result as sent on the output stream.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       hold_select;
    logic [1:0] status;
    logic       last;
  } res_t;
endpackage

@@ rtl/core/sfcs_front.sv @@
// Front part: accepts requests and checks command requests against bus ownership, chip, opcode and the flash geometry.
module sfcs_front import sfcs_pkg::*; #(
  parameter int FLASH_BYTES  = 262144,
  parameter int MAX_TRANSFER = 4096,
  parameter int PAGE_BYTES   = 256,
  parameter int SECTOR_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  opcode,
  input  logic [23:0] address,
  input  logic [15:0] length,
  input  logic [1:0]  chip,
  input  logic        bus_owned,
  input  logic [7:0]  rx_byte,
  input  logic        rx_error,
  input  logic [7:0]  write_byte,
  output logic        q_valid,
  input  logic        q_ready,
  output req_t        q_data
);
  localparam int PB = $clog2(PAGE_BYTES);
  localparam int SB = $clog2(SECTOR_BYTES);

  logic        xfer;
  logic        bad;
  logic [25:0] sum;
  logic [16:0] page_end;
  req_t        req;

  always_comb begin
    xfer = (opcode == OPC_READ) || (opcode == OPC_PROGRAM);
    sum = {2'b0, address} + {10'b0, length};
    page_end = {1'b0, 16'(address[PB-1:0])} + {1'b0, length};
    bad = 1'b0;
    if (!bus_owned || chip != 2'd0 || {2'b0, address} >= 26'(FLASH_BYTES) ||
        {10'b0, length} > 26'(MAX_TRANSFER) || sum > 26'(FLASH_BYTES)) begin
      bad = 1'b1;
    end else if (xfer) begin
      if (length == 16'd0 ||
          (opcode == OPC_PROGRAM && page_end > 17'(PAGE_BYTES))) begin
        bad = 1'b1;
      end
    end else if (length != 16'd0 ||
                 (opcode != OPC_ERASE && opcode != OPC_WREN && opcode != OPC_WRDI) ||
                 (opcode == OPC_ERASE && address[SB-1:0] != '0)) begin
      bad = 1'b1;
    end
    req.mode = mode;
    req.cmd_bad = bad;
    req.opcode = opcode;
    req.address = address;
    req.length = length[12:0];
    req.cmd_ok_bus = 1'b1;
    req.rx_byte = rx_byte;
    req.rx_error = rx_error;
    req.write_byte = write_byte;
  end

  // Single register stage: refills in the cycle it drains.
  assign in_ready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      q_data <= req;
    end
  end
endmodule

@@ rtl/core/sfcs_back.sv @@
// Back part: the transaction state machine that turns requests into frames, read data and done results.
module sfcs_back import sfcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [21:0] cfg_data,
  input  logic        q_valid,
  output logic        q_ready,
  input  req_t        q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_data
);
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_POLL_CMD  = 3'd1;
  localparam logic [2:0] PH_POLL_READ = 3'd2;
  localparam logic [2:0] PH_OPCODE    = 3'd3;
  localparam logic [2:0] PH_ADDR      = 3'd4;
  localparam logic [2:0] PH_DATA      = 3'd5;

  logic [15:0] word_timeout;
  logic [21:0] poll_timeout;
  logic [2:0]  phase, phase_next;
  logic        faulted, faulted_next;
  logic [7:0]  cur_op, cur_op_next;
  logic [23:0] cur_addr, cur_addr_next;
  logic [12:0] bytes_left, bytes_left_next;
  logic [1:0]  abi, abi_next;
  logic [15:0] word_ticks, word_ticks_next;
  logic [21:0] poll_ticks, poll_ticks_next;
  logic [1:0]  pmask, pmask_next, pexp, pexp_next;
  logic        fin, fin_next;

  // Output buffer of up to two results; a second result is a frame following read data.
  logic        r0_v, r1_v;
  res_t        r0, r1;
  logic        n_cnt0, n_cnt1;
  res_t        n0, n1;
  logic        is_xfer, take;
  logic [7:0]  abyte;

  assign q_ready = !r1_v && (!r0_v || out_ready);
  assign take = q_valid && q_ready;
  assign out_valid = r0_v;
  assign out_data = r0;
  assign is_xfer = (cur_op == OPC_READ) || (cur_op == OPC_PROGRAM);

  function automatic res_t mk(logic [1:0] k, logic [7:0] b, logic h, logic [1:0] s,
                              logic l);
    res_t r;
    r.kind = k;
    r.out_byte = b;
    r.hold_select = h;
    r.status = s;
    r.last = l;
    return r;
  endfunction

  always_comb begin
    logic       emit;
    res_t       e;
    logic [1:0] ai;
    phase_next = phase;
    faulted_next = faulted;
    cur_op_next = cur_op;
    cur_addr_next = cur_addr;
    bytes_left_next = bytes_left;
    abi_next = abi;
    word_ticks_next = word_ticks;
    poll_ticks_next = poll_ticks;
    pmask_next = pmask;
    pexp_next = pexp;
    fin_next = fin;
    n_cnt0 = 1'b0;
    n_cnt1 = 1'b0;
    n0 = mk(KIND_DATA, q_data.rx_byte, 1'b0, ST_OK, 1'b0);
    emit = 1'b0;
    e = mk(KIND_DONE, 8'd0, 1'b0, ST_OK, 1'b1);
    ai = 2'd0;
    abyte = 8'd0;
    if (take) begin
      case (q_data.mode)
        MODE_CMD: begin
          if (phase == PH_IDLE) begin
            emit = 1'b1;
            if (q_data.cmd_bad || faulted) begin
              e = mk(KIND_DONE, 8'd0, 1'b0, ST_ERROR, 1'b1);
            end else begin
              cur_op_next = q_data.opcode;
              cur_addr_next = q_data.address;
              bytes_left_next = q_data.length;
              abi_next = 2'd0;
              phase_next = PH_POLL_CMD;
              fin_next = 1'b0;
              pmask_next = 2'd1;
              pexp_next = 2'd0;
              poll_ticks_next = '0;
              word_ticks_next = '0;
              e = mk(KIND_FRAME, OPC_RDSR, 1'b1, ST_OK, 1'b1);
            end
          end
        end
        MODE_TICK: begin
          if (phase != PH_IDLE) begin
            if (word_ticks != 16'hFFFF) word_ticks_next = word_ticks + 16'd1;
            if ((phase == PH_POLL_CMD || phase == PH_POLL_READ) &&
                poll_ticks != 22'h3FFFFF) poll_ticks_next = poll_ticks + 22'd1;
            if (word_ticks_next >= word_timeout) begin
              emit = 1'b1;
              e = mk(KIND_DONE, 8'd0, 1'b0, ST_TIMEOUT, 1'b1);
              faulted_next = 1'b1;
              phase_next = PH_IDLE;
              fin_next = 1'b0;
            end
          end
        end
        MODE_RX: begin
          if (phase != PH_IDLE) begin
            emit = 1'b1;
            if (q_data.rx_error) begin
              e = mk(KIND_DONE, 8'd0, 1'b0, ST_ERROR, 1'b1);
              faulted_next = 1'b1;
              phase_next = PH_IDLE;
              fin_next = 1'b0;
            end else begin
              // Every path below sends a frame or finishes; do_final marks the paths that start the final poll.
              logic do_final;
              do_final = 1'b0;
              case (phase)
                PH_POLL_CMD: begin
                  phase_next = PH_POLL_READ;
                  e = mk(KIND_FRAME, 8'd0, 1'b0, ST_OK, 1'b1);
                end
                PH_POLL_READ: begin
                  if ((q_data.rx_byte[1:0] & pmask) == pexp) begin
                    if (fin) begin
                      e = mk(KIND_DONE, 8'd0, 1'b0, ST_OK, 1'b1);
                      phase_next = PH_IDLE;
                      fin_next = 1'b0;
                    end else begin
                      phase_next = PH_OPCODE;
                      e = mk(KIND_FRAME, cur_op, is_xfer || cur_op == OPC_ERASE,
                             ST_OK, 1'b1);
                    end
                  end else if (poll_ticks >= poll_timeout) begin
                    e = mk(KIND_DONE, 8'd0, 1'b0, ST_TIMEOUT, 1'b1);
                    faulted_next = 1'b1;
                    phase_next = PH_IDLE;
                    fin_next = 1'b0;
                  end else begin
                    phase_next = PH_POLL_CMD;
                    e = mk(KIND_FRAME, OPC_RDSR, 1'b1, ST_OK, 1'b1);
                  end
                end
                PH_OPCODE: begin
                  if (is_xfer || cur_op == OPC_ERASE) begin
                    phase_next = PH_ADDR;
                    abi_next = 2'd0;
                    e = mk(KIND_FRAME, cur_addr[23:16], 1'b1, ST_OK, 1'b1);
                  end else begin
                    do_final = 1'b1;
                  end
                end
                PH_ADDR: begin
                  if (abi < 2'd2) begin
                    ai = abi + 2'd1;
                    abi_next = ai;
                    abyte = (ai == 2'd1) ? cur_addr[15:8] : cur_addr[7:0];
                    e = mk(KIND_FRAME, abyte, (ai < 2'd2) || is_xfer, ST_OK, 1'b1);
                  end else if (!is_xfer || bytes_left == 13'd0) begin
                    do_final = 1'b1;
                  end else begin
                    phase_next = PH_DATA;
                    bytes_left_next = bytes_left - 13'd1;
                    e = mk(KIND_FRAME, (cur_op == OPC_PROGRAM) ? q_data.write_byte : 8'd0,
                           bytes_left_next != 13'd0, ST_OK, 1'b1);
                  end
                end
                PH_DATA: begin
                  n_cnt0 = (cur_op == OPC_READ);
                  if (bytes_left == 13'd0) begin
                    do_final = 1'b1;
                  end else begin
                    bytes_left_next = bytes_left - 13'd1;
                    e = mk(KIND_FRAME, (cur_op == OPC_PROGRAM) ? q_data.write_byte : 8'd0,
                           bytes_left_next != 13'd0, ST_OK, 1'b1);
                  end
                end
                default: begin
                  phase_next = PH_IDLE;
                  emit = 1'b0;
                end
              endcase
              if (do_final) begin
                phase_next = PH_POLL_CMD;
                fin_next = 1'b1;
                pmask_next = (cur_op == OPC_WREN || cur_op == OPC_WRDI) ? 2'd3 : 2'd1;
                pexp_next = (cur_op == OPC_WREN) ? 2'd2 : 2'd0;
                poll_ticks_next = '0;
                e = mk(KIND_FRAME, OPC_RDSR, 1'b1, ST_OK, 1'b1);
              end
            end
            if (emit && e.kind == KIND_FRAME) word_ticks_next = '0;
          end
        end
        default: begin
        end
      endcase
    end
    // Lay out results: optional read data first, then the emitted result.
    if (n_cnt0) begin
      n1 = e;
      n_cnt1 = emit;
    end else begin
      n0 = e;
      n_cnt0 = emit;
      n1 = e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_timeout <= 16'd1000;
      poll_timeout <= 22'd2000000;
      phase <= PH_IDLE;
      faulted <= 1'b0;
      cur_op <= '0;
      cur_addr <= '0;
      bytes_left <= '0;
      abi <= '0;
      word_ticks <= '0;
      poll_ticks <= '0;
      pmask <= '0;
      pexp <= '0;
      fin <= 1'b0;
      r0_v <= 1'b0;
      r1_v <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WORD_TIMEOUT) word_timeout <= cfg_data[15:0];
        else poll_timeout <= cfg_data;
      end
      phase <= phase_next;
      faulted <= faulted_next;
      cur_op <= cur_op_next;
      cur_addr <= cur_addr_next;
      bytes_left <= bytes_left_next;
      abi <= abi_next;
      word_ticks <= word_ticks_next;
      poll_ticks <= poll_ticks_next;
      pmask <= pmask_next;
      pexp <= pexp_next;
      fin <= fin_next;
      if (take) begin
        // Buffer is empty or draining now; load new results.
        r0_v <= n_cnt0;
        r1_v <= n_cnt1;
        r0 <= n0;
        r1 <= n1;
      end else if (r0_v && out_ready) begin
        r0_v <= r1_v;
        r0 <= r1;
        r1_v <= 1'b0;
      end
    end
  end
endmodule

@@ rtl/core/spi_flash_command_sequencer_unit.sv @@
// Top level of the SPI NOR flash command sequencer.
// The block runs one flash transaction at a time. A command request is checked
// by the front stage (bus ownership, chip, range, page and sector rules) and a
// rejected request returns one done result with error status. A good request
// starts a status poll, then opcode, three address bytes and data frames, each
// one output result carrying a chip-select-hold flag; received-byte requests
// advance the sequence and tick requests time out frames and polls. A timeout
// or receive error sets a sticky fault that only reset clears. The request
// type travels on s_tuser and the result kind on m_tuser. The back state
// machine handles each request as it is taken, so one request per clock is
// sustained while the output is taken. A request passes the front register
// and then the output buffer before its first result is valid and can be
// taken. A read data byte plus the next frame produce two results, which the
// two-entry output buffer holds; the input then waits while the second result
// leaves. Configuration writes are taken at any time but are meant for idle
// periods.
module spi_flash_command_sequencer_unit import sfcs_pkg::*; #(
  parameter int FLASH_BYTES  = 262144,
  parameter int MAX_TRANSFER = 4096,
  parameter int PAGE_BYTES   = 256,
  parameter int SECTOR_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode[7:0], address[31:8], length[47:32], chip[49:48], bus_owned[50],
  // rx_byte[58:51], rx_error[59], write_byte[67:60], zero fill
  input  logic [71:0] s_tdata,
  // mode[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_byte[7:0], hold_select[8], status[10:9], zero fill
  output logic [15:0] m_tdata,
  // kind[1:0]
  output logic [1:0]  m_tuser,
  // last
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [21:0] cfg_data
);
  logic q_valid, q_ready;
  req_t q_data;
  res_t res;

  sfcs_front #(
    .FLASH_BYTES(FLASH_BYTES), .MAX_TRANSFER(MAX_TRANSFER),
    .PAGE_BYTES(PAGE_BYTES), .SECTOR_BYTES(SECTOR_BYTES)
  ) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .mode(s_tuser), .opcode(s_tdata[7:0]), .address(s_tdata[31:8]),
    .length(s_tdata[47:32]), .chip(s_tdata[49:48]), .bus_owned(s_tdata[50]),
    .rx_byte(s_tdata[58:51]), .rx_error(s_tdata[59]), .write_byte(s_tdata[67:60]),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  sfcs_back u_back (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(res)
  );

  assign m_tdata = {5'b0, res.status, res.hold_select, res.out_byte};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;
endmodule

@@ sim/tb.sv @@
// Self-checking testbench of the SPI flash command sequencer.
`timescale 1ns / 1ps

module tb import sfcs_pkg::*; ();

  // A mode value that the block must ignore.
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int FLASH_SIZE = 262144;
  localparam int XFER_MAX = 4096;
  localparam int PAGE_SIZE = 256;
  localparam int SECTOR_SIZE = 4096;
  // Cycles that let the block's pipeline drain after the last result.
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 500000;

  // One request as it travels on the input stream.
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  opcode;
    logic [23:0] address;
    logic [15:0] length;
    logic [1:0]  chip;
    logic        bus_owned;
    logic [7:0]  rx_byte;
    logic        rx_error;
    logic [7:0]  write_byte;
  } flash_req_t;

  typedef enum logic [2:0] {
    SQ_IDLE, SQ_POLL_CMD, SQ_POLL_READ, SQ_OPCODE, SQ_ADDR, SQ_DATA
  } seq_phase_e;

  // Everything the sequencer remembers, including its two timeout settings.
  typedef struct {
    seq_phase_e  phase;
    bit          faulted;
    logic [7:0]  opc;
    logic [23:0] addr;
    logic [12:0] left;
    logic [1:0]  addr_idx;
    logic [15:0] word_ticks;
    logic [21:0] poll_ticks;
    logic [1:0]  poll_mask;
    logic [1:0]  poll_want;
    bit          final_poll;
    logic [15:0] word_limit;
    logic [21:0] poll_limit;
  } seq_state_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we;
  logic        cfg_index;
  logic [21:0] cfg_data;

  spi_flash_command_sequencer_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The sequencer state as the block should hold it (updated on accepted
  // requests) and the state the stimulus planner tracks ahead of the driver.
  seq_state_t  dut_model;
  seq_state_t  plan;
  flash_req_t  pending_reqs[$];
  res_t        expected_frames[$];
  int          fails = 0;
  bit          calm = 1'b0;
  bit          hold_go = 1'b0;
  bit          hold_done;
  int          hold_left;
  int          req_count = 0;

  function automatic void seq_clear(inout seq_state_t s);
    s.phase = SQ_IDLE;
    s.faulted = 1'b0;
    s.opc = '0;
    s.addr = '0;
    s.left = '0;
    s.addr_idx = '0;
    s.word_ticks = '0;
    s.poll_ticks = '0;
    s.poll_mask = '0;
    s.poll_want = '0;
    s.final_poll = 1'b0;
    s.word_limit = 16'd1000;
    s.poll_limit = 22'd2000000;
  endfunction

  function automatic res_t mk_res(logic [1:0] kind, logic [7:0] b, logic hold,
                                  logic [1:0] st, logic last);
    res_t r;
    r.kind = kind;
    r.out_byte = b;
    r.hold_select = hold;
    r.status = st;
    r.last = last;
    return r;
  endfunction

  function automatic res_t seq_send(inout seq_state_t s, input logic [7:0] b,
                                    input logic hold);
    s.word_ticks = '0;
    return mk_res(KIND_FRAME, b, hold, ST_OK, 1'b1);
  endfunction

  function automatic res_t seq_finish(inout seq_state_t s, input logic [1:0] st);
    if (st != ST_OK) s.faulted = 1'b1;
    s.phase = SQ_IDLE;
    s.final_poll = 1'b0;
    return mk_res(KIND_DONE, 8'd0, 1'b0, st, 1'b1);
  endfunction

  function automatic res_t seq_poll(inout seq_state_t s, input bit fin,
                                    input logic [1:0] mask, input logic [1:0] want);
    s.phase = SQ_POLL_CMD;
    s.final_poll = fin;
    s.poll_mask = mask;
    s.poll_want = want;
    s.poll_ticks = '0;
    return seq_send(s, OPC_RDSR, 1'b1);
  endfunction

  // The closing status poll waits for the condition the opcode leaves behind.
  function automatic res_t seq_final_poll(inout seq_state_t s);
    if (s.opc == OPC_WREN) return seq_poll(s, 1'b1, 2'd3, 2'd2);
    if (s.opc == OPC_WRDI) return seq_poll(s, 1'b1, 2'd3, 2'd0);
    return seq_poll(s, 1'b1, 2'd1, 2'd0);
  endfunction

  // Advances the sequencer by one request; returns the number of results.
  function automatic int seq_step(inout seq_state_t s, input flash_req_t q,
                                  output res_t r0, output res_t r1);
    bit xfer;
    bit bad;
    int unsigned a;
    int unsigned l;
    logic [1:0] i;
    r0 = '0;
    r1 = '0;
    xfer = (s.opc == OPC_READ) || (s.opc == OPC_PROGRAM);
    a = {8'd0, q.address};
    l = {16'd0, q.length};
    case (q.mode)
      MODE_CMD: begin
        if (s.phase != SQ_IDLE) return 0;
        bad = 1'b0;
        if (!q.bus_owned || s.faulted || q.chip != 2'd0 || a >= FLASH_SIZE ||
            l > XFER_MAX || a + l > FLASH_SIZE)
          bad = 1'b1;
        else if (q.opcode == OPC_READ || q.opcode == OPC_PROGRAM) begin
          if (l == 0 || (q.opcode == OPC_PROGRAM && (a % PAGE_SIZE) + l > PAGE_SIZE))
            bad = 1'b1;
        end else if (l != 0 ||
                     (q.opcode != OPC_ERASE && q.opcode != OPC_WREN &&
                      q.opcode != OPC_WRDI) ||
                     (q.opcode == OPC_ERASE && (a % SECTOR_SIZE) != 0))
          bad = 1'b1;
        if (bad) begin
          r0 = mk_res(KIND_DONE, 8'd0, 1'b0, ST_ERROR, 1'b1);
          return 1;
        end
        s.opc = q.opcode;
        s.addr = q.address;
        s.left = q.length[12:0];
        s.addr_idx = '0;
        r0 = seq_poll(s, 1'b0, 2'd1, 2'd0);
        return 1;
      end
      MODE_TICK: begin
        if (s.phase == SQ_IDLE) return 0;
        if (s.word_ticks != 16'hFFFF) s.word_ticks++;
        if ((s.phase == SQ_POLL_CMD || s.phase == SQ_POLL_READ) &&
            s.poll_ticks != 22'h3FFFFF)
          s.poll_ticks++;
        if (s.word_ticks >= s.word_limit) begin
          r0 = seq_finish(s, ST_TIMEOUT);
          return 1;
        end
        return 0;
      end
      MODE_RX: begin
        if (s.phase == SQ_IDLE) return 0;
        if (q.rx_error) begin
          r0 = seq_finish(s, ST_ERROR);
          return 1;
        end
        case (s.phase)
          SQ_POLL_CMD: begin
            s.phase = SQ_POLL_READ;
            r0 = seq_send(s, 8'd0, 1'b0);
          end
          SQ_POLL_READ: begin
            if ((q.rx_byte[1:0] & s.poll_mask) == s.poll_want) begin
              if (s.final_poll) r0 = seq_finish(s, ST_OK);
              else begin
                s.phase = SQ_OPCODE;
                r0 = seq_send(s, s.opc, xfer || s.opc == OPC_ERASE);
              end
            end else if (s.poll_ticks >= s.poll_limit)
              r0 = seq_finish(s, ST_TIMEOUT);
            else begin
              s.phase = SQ_POLL_CMD;
              r0 = seq_send(s, OPC_RDSR, 1'b1);
            end
          end
          SQ_OPCODE: begin
            if (xfer || s.opc == OPC_ERASE) begin
              s.phase = SQ_ADDR;
              s.addr_idx = '0;
              r0 = seq_send(s, s.addr[23:16], 1'b1);
            end else
              r0 = seq_final_poll(s);
          end
          SQ_ADDR: begin
            if (s.addr_idx < 2) begin
              i = s.addr_idx + 2'd1;
              s.addr_idx = i;
              r0 = seq_send(s, (i == 2'd1) ? s.addr[15:8] : s.addr[7:0],
                            i < 2 || xfer);
            end else if (!xfer || s.left == 0)
              r0 = seq_final_poll(s);
            else begin
              s.phase = SQ_DATA;
              s.left = s.left - 13'd1;
              r0 = seq_send(s, (s.opc == OPC_PROGRAM) ? q.write_byte : 8'd0,
                            s.left != 0);
            end
          end
          default: begin
            // Data phase: a read hands back the byte before the next frame.
            if (s.opc == OPC_READ) begin
              r0 = mk_res(KIND_DATA, q.rx_byte, 1'b0, ST_OK, 1'b0);
              if (s.left == 0) r1 = seq_final_poll(s);
              else begin
                s.left = s.left - 13'd1;
                r1 = seq_send(s, 8'd0, s.left != 0);
              end
              return 2;
            end
            if (s.left == 0) r0 = seq_final_poll(s);
            else begin
              s.left = s.left - 13'd1;
              r0 = seq_send(s, q.write_byte, s.left != 0);
            end
          end
        endcase
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic flash_req_t any_req();
    flash_req_t q;
    q = 70'({$urandom, $urandom, $urandom});
    return q;
  endfunction

  // Queues a request as is and keeps the planner in step with it.
  task automatic offer(input flash_req_t q);
    res_t d0;
    res_t d1;
    int n;
    n = seq_step(plan, q, d0, d1);
    pending_reqs.push_back(q);
    req_count++;
  endtask

  // Queues a request unless it would fault the block; a harmless received
  // byte that satisfies any pending poll goes in its place.
  task automatic offer_safe(input flash_req_t q);
    seq_state_t trial;
    res_t d0;
    res_t d1;
    int n;
    trial = plan;
    n = seq_step(trial, q, d0, d1);
    if (trial.faulted && !plan.faulted) begin
      q.mode = MODE_RX;
      q.rx_error = 1'b0;
      q.rx_byte[1:0] = plan.poll_want;
    end
    offer(q);
  endtask

  function automatic flash_req_t good_cmd(logic [7:0] opc);
    flash_req_t q;
    int unsigned l;
    q = any_req();
    q.mode = MODE_CMD;
    q.opcode = opc;
    q.chip = 2'd0;
    q.bus_owned = 1'b1;
    l = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    case (opc)
      OPC_READ: begin
        q.length = 16'(l);
        q.address = 24'($urandom_range(0, FLASH_SIZE - l));
      end
      OPC_PROGRAM: begin
        q.length = 16'(l);
        q.address = 24'($urandom_range(0, FLASH_SIZE / PAGE_SIZE - 1) * PAGE_SIZE +
                        $urandom_range(0, PAGE_SIZE - l));
      end
      OPC_ERASE: begin
        q.length = '0;
        q.address = 24'($urandom_range(0, FLASH_SIZE / SECTOR_SIZE - 1) * SECTOR_SIZE);
      end
      default: begin
        q.length = '0;
        q.address = 24'($urandom_range(0, FLASH_SIZE - 1));
      end
    endcase
    return q;
  endfunction

  // Offers a command and then feeds received bytes, ticks and some noise
  // until the transaction is over.
  task automatic run_txn(input flash_req_t cmd);
    flash_req_t q;
    int steps;
    int r;
    offer_safe(cmd);
    steps = 0;
    while (plan.phase != SQ_IDLE) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        q = any_req();
        q.mode = MODE_TICK;
      end else if (r < 18)
        q = any_req();
      else begin
        q = any_req();
        q.mode = MODE_RX;
        q.rx_error = 1'b0;
        if (steps > 60 || $urandom_range(0, 9) < 7) q.rx_byte[1:0] = plan.poll_want;
      end
      offer_safe(q);
      steps++;
    end
  endtask

  function automatic logic [7:0] pick_opcode();
    case ($urandom_range(0, 4))
      0: return OPC_READ;
      1: return OPC_PROGRAM;
      2: return OPC_ERASE;
      3: return OPC_WREN;
      default: return OPC_WRDI;
    endcase
  endfunction

  // Waits at falling edges until every request is taken and every result seen.
  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || expected_frames.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [21:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_WORD_TIMEOUT) begin
      dut_model.word_limit = val[15:0];
      plan.word_limit = val[15:0];
    end else begin
      dut_model.poll_limit = val;
      plan.poll_limit = val;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Driver: presents the queued requests with random gaps (none while calm) and
  // predicts the results of each request the moment it is accepted.
  flash_req_t on_bus;
  int         send_gap = 0;
  always @(posedge clk) begin
    res_t e0;
    res_t e1;
    int n;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        n = seq_step(dut_model, on_bus, e0, e1);
        if (n > 0) expected_frames.push_back(e0);
        if (n > 1) expected_frames.push_back(e1);
      end
      if (send_gap != 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        on_bus = pending_reqs.pop_front();
        s_tdata <= {4'b0000, on_bus.write_byte, on_bus.rx_error, on_bus.rx_byte,
                    on_bus.bus_owned, on_bus.chip, on_bus.length, on_bus.address,
                    on_bus.opcode};
        s_tuser <= on_bus.mode;
        s_tvalid <= 1'b1;
        send_gap = calm ? 0 : idle_len();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started once by the stimulus, so the block's
  // output buffer fills and it must stall its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  int recv_stall = 0;
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_frames.size() == 0) begin
          $error("unexpected result: tuser %h tdata %h tlast %b", m_tuser, m_tdata,
                 m_tlast);
          fails++;
        end else begin
          want = expected_frames.pop_front();
          if (m_tuser != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, m_tuser);
            fails++;
          end
          if (m_tdata[7:0] != want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, m_tdata[7:0]);
            fails++;
          end
          if (m_tdata[8] != want.hold_select) begin
            $error("hold_select: expected %b, got %b", want.hold_select, m_tdata[8]);
            fails++;
          end
          if (m_tdata[10:9] != want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tdata[10:9]);
            fails++;
          end
          if (m_tlast != want.last) begin
            $error("last: expected %b, got %b", want.last, m_tlast);
            fails++;
          end
        end
      end
      if (recv_stall != 0) recv_stall--;
      else if (!calm) recv_stall = idle_len();
      m_tready <= (hold_left == 0) && (recv_stall == 0);
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    flash_req_t q;
    int k;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    seq_clear(dut_model);
    seq_clear(plan);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the reset timeouts: ignored items, each rejection
    // rule of the front stage, then a transaction of every opcode.
    q = good_cmd(OPC_WREN);
    q.mode = MODE_TICK; offer(q);
    q.mode = MODE_RX; offer(q);
    q.mode = MODE_NONE; offer(q);
    q = good_cmd(OPC_WREN); q.bus_owned = 1'b0; offer(q);
    q = good_cmd(OPC_WREN); q.chip = 2'd2; offer(q);
    q = good_cmd(OPC_WRDI); q.address = 24'h040000; offer(q);
    q = good_cmd(OPC_READ); q.address = 24'h0; q.length = 16'd4097; offer(q);
    q = good_cmd(OPC_READ); q.address = 24'h03FFFF; q.length = 16'd2; offer(q);
    q = good_cmd(OPC_READ); q.length = 16'd0; offer(q);
    q = good_cmd(OPC_PROGRAM); q.address = 24'h0000FF; q.length = 16'd2; offer(q);
    q = good_cmd(OPC_ERASE); q.address = 24'h001001; offer(q);
    q = good_cmd(OPC_WREN); q.length = 16'd1; offer(q);
    q = good_cmd(OPC_WREN); q.opcode = 8'hFF; offer(q);
    q = good_cmd(OPC_READ); q.address = 24'hFFFFFF; q.length = 16'hFFFF; offer(q);
    run_txn(good_cmd(OPC_WREN));
    run_txn(good_cmd(OPC_WRDI));
    q = good_cmd(OPC_ERASE); q.address = 24'h03F000; run_txn(q);
    q = good_cmd(OPC_READ); q.address = 24'h0; q.length = 16'd1; run_txn(q);
    q = good_cmd(OPC_PROGRAM); q.address = 24'h03FFFE; q.length = 16'd2; run_txn(q);
    // A read that ends exactly at the top of the flash.
    q = good_cmd(OPC_READ); q.address = 24'h03FFF8; q.length = 16'd8; run_txn(q);
    drain();

    // Widest timeouts; the first stretch runs with no idling at all, and the
    // receiver's long hold-off lands in it.
    write_reg(REG_WORD_TIMEOUT, 22'd65535);
    write_reg(REG_POLL_TIMEOUT, 22'h3FFFFF);
    calm = 1'b1;
    hold_go = 1'b1;
    while (req_count < 200) begin
      if (calm && req_count > 120) begin
        // Let the unthrottled stretch go out before idling starts.
        while (pending_reqs.size() != 0) @(negedge clk);
        calm = 1'b0;
      end
      if ($urandom_range(0, 6) == 0) offer_safe(any_req());
      else run_txn(good_cmd(pick_opcode()));
    end
    // The sender stops here until every result is back.
    drain();

    write_reg(REG_WORD_TIMEOUT, 22'($urandom_range(16, 200)));
    write_reg(REG_POLL_TIMEOUT, 22'($urandom_range(50, 2000)));
    while (req_count < 370) begin
      if ($urandom_range(0, 6) == 0) offer_safe(any_req());
      else run_txn(good_cmd(pick_opcode()));
    end
    drain();

    // Fault at the end: a receive error, a frame timeout or a poll timeout.
    k = $urandom_range(0, 2);
    if (k == 1) write_reg(REG_WORD_TIMEOUT, 22'd1);
    else write_reg(REG_WORD_TIMEOUT, 22'd2);
    write_reg(REG_POLL_TIMEOUT, 22'd1);
    offer(good_cmd(OPC_WREN));
    q = any_req();
    q.rx_error = 1'b0;
    if (k == 0) begin
      q.mode = MODE_RX; q.rx_error = 1'b1; offer(q);
    end else if (k == 1) begin
      q.mode = MODE_TICK; offer(q);
    end else begin
      q.mode = MODE_RX; offer(q);
      q.mode = MODE_TICK; offer(q);
      q.mode = MODE_RX; q.rx_byte[0] = 1'b1; offer(q);
    end
    // A faulted block rejects even good commands.
    offer(good_cmd(OPC_WREN));
    offer(good_cmd(OPC_READ));
    drain();

    if (expected_frames.size() != 0) begin
      $error("%0d expected results never arrived", expected_frames.size());
      fails++;
    end
    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
